FILE: src/slpe_pkg.sv
// slpe_pkg: widths, reset values, opcodes and register indexes for the
// serial LED pulse encoder. No dependencies; compiled before all other files.

package slpe_pkg;

  localparam int OPCODE_W     = 2;
  localparam int PIX_IDX_W    = 6;
  localparam int PIX_W        = 24;
  localparam int TIME_W       = 16;
  localparam int LED_CNT_W    = 7;
  localparam int BIT_POS_W    = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int MAX_LEDS_DEF = 64;

  localparam logic [BIT_POS_W-1:0] TOP_BIT            = 5'd23;
  localparam logic [TIME_W-1:0]    BIT_PERIOD_RST     = 16'd118;
  localparam logic [TIME_W-1:0]    HIGH_ONE_RST       = 16'd75;
  localparam logic [TIME_W-1:0]    HIGH_ZERO_RST      = 16'd40;
  localparam logic [LED_CNT_W-1:0] LED_COUNT_RST      = 7'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD = 2'd0,
    CFG_HIGH_ONE   = 2'd1,
    CFG_HIGH_ZERO  = 2'd2,
    CFG_LED_COUNT  = 2'd3
  } cfg_idx_t;

endpackage

FILE: src/slpe_if.sv
// slpe_if: item, result and configuration channels of the pulse encoder.
// Depends on slpe_pkg for field widths.

interface slpe_in_if import slpe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [PIX_IDX_W-1:0] pixel_index;
  logic [PIX_W-1:0]     pixel_word;

  modport source (output valid, output opcode, output pixel_index, output pixel_word,
                  input ready);
  modport sink   (input valid, input opcode, input pixel_index, input pixel_word,
                  output ready);
endinterface

interface slpe_out_if ();
  logic valid;
  logic ready;
  logic data_line;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output data_line, output busy_res, output frame_done,
                  input ready);
  modport sink   (input valid, input data_line, input busy_res, input frame_done,
                  output ready);
endinterface

interface slpe_cfg_if import slpe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: src/serial_led_pulse_encoder.sv
// serial_led_pulse_encoder: one-wire LED chain pulse encoder, pixel words
// held in a synchronous memory. Depends on slpe_pkg and slpe_if.
// A result passes the memory read register and then the output register, and
// can be held at either while a result waits. Throughput: one item per cycle,
// one pixel memory read per item; the input stalls only while a result waits. Reset
// (rst_n low, synchronous) clears frame state and pipeline valids, loads register defaults; memory not cleared.

module serial_led_pulse_encoder import slpe_pkg::*; #(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  slpe_in_if.sink     in_ch,
  slpe_out_if.source  out_ch,
  slpe_cfg_if.sink    cfg_ch
);

  localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // configuration
  logic [TIME_W-1:0]    bit_period_r;
  logic [TIME_W-1:0]    high_one_r;
  logic [TIME_W-1:0]    high_zero_r;
  logic [LED_CNT_W-1:0] led_count_r;

  // frame state
  logic [TIME_W-1:0]    phase_r, phase_nxt;
  logic [BIT_POS_W-1:0] bit_pos_r, bit_pos_nxt;
  logic [LED_CNT_W-1:0] led_pos_r, led_pos_nxt;
  logic                 sending_r, sending_nxt;
  logic                 done_nxt;

  // memory stage
  logic [PIX_W-1:0]     pix_mem [MAX_LEDS];
  logic [PIX_W-1:0]     rd_data_r;
  logic                 s1_v_r;
  logic                 s1_active_r;
  logic [TIME_W-1:0]    s1_phase_r;
  logic [BIT_POS_W-1:0] s1_bit_r;
  logic                 s1_busy_r;
  logic                 s1_done_r;

  // output register
  logic                 out_v_r;
  logic                 line_r;
  logic                 busy_r;
  logic                 done_r;

  logic                 in_acc;
  logic                 s1_move;
  logic                 tick_active;
  logic [31:0]          led_cnt_ext;
  logic [LED_CNT_W-1:0] frame_leds;
  logic [31:0]          slot_ext;
  logic [31:0]          led_ext;
  logic                 slot_ok;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [TIME_W-1:0]    phase_inc;
  logic [LED_CNT_W-1:0] led_inc;
  logic                 pix_bit;
  logic [TIME_W-1:0]    high_sel;
  logic                 line_w;

  assign s1_move      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_move;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign led_cnt_ext = {{(32-LED_CNT_W){1'b0}}, led_count_r};
  assign frame_leds  = (led_cnt_ext > 32'(MAX_LEDS)) ? LED_CNT_W'(MAX_LEDS) : led_count_r;
  assign slot_ext    = {{(32-PIX_IDX_W){1'b0}}, in_ch.pixel_index};
  assign slot_ok     = slot_ext < 32'(MAX_LEDS);
  assign wr_addr     = slot_ext[ADDR_W-1:0];
  assign led_ext     = {{(32-LED_CNT_W){1'b0}}, led_pos_r};
  assign rd_addr     = led_ext[ADDR_W-1:0];
  assign tick_active = (in_ch.opcode == OP_TICK) && sending_r;
  assign phase_inc   = phase_r + 1'b1;
  assign led_inc     = led_pos_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    bit_pos_nxt = bit_pos_r;
    led_pos_nxt = led_pos_r;
    sending_nxt = sending_r;
    done_nxt    = 1'b0;
    case (in_ch.opcode)
      OP_TICK: begin
        if (sending_r) begin
          if ((phase_inc >= bit_period_r) || (phase_inc == '0)) begin
            phase_nxt = '0;
            if (bit_pos_r == '0) begin
              bit_pos_nxt = TOP_BIT;
              if (led_inc >= frame_leds) begin
                sending_nxt = 1'b0;
                led_pos_nxt = '0;
                done_nxt    = 1'b1;
              end else begin
                led_pos_nxt = led_inc;
              end
            end else begin
              bit_pos_nxt = bit_pos_r - 1'b1;
            end
          end else begin
            phase_nxt = phase_inc;
          end
        end
      end
      OP_START: begin
        if (!sending_r) begin
          phase_nxt   = '0;
          bit_pos_nxt = TOP_BIT;
          led_pos_nxt = '0;
          if (frame_leds == '0) begin
            done_nxt = 1'b1;
          end else begin
            sending_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RST;
      high_one_r   <= HIGH_ONE_RST;
      high_zero_r  <= HIGH_ZERO_RST;
      led_count_r  <= LED_COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_BIT_PERIOD: bit_period_r <= cfg_ch.wr_data;
        CFG_HIGH_ONE:   high_one_r   <= cfg_ch.wr_data;
        CFG_HIGH_ZERO:  high_zero_r  <= cfg_ch.wr_data;
        CFG_LED_COUNT:  led_count_r  <= cfg_ch.wr_data[LED_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      bit_pos_r <= TOP_BIT;
      led_pos_r <= '0;
      sending_r <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      bit_pos_r <= bit_pos_nxt;
      led_pos_r <= led_pos_nxt;
      sending_r <= sending_nxt;
    end
  end

  // pixel memory: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.opcode == OP_LOAD) && slot_ok) begin
      pix_mem[wr_addr] <= in_ch.pixel_word;
    end
    if (in_acc) begin
      rd_data_r <= pix_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_active_r <= tick_active;
      s1_phase_r  <= phase_r;
      s1_bit_r    <= bit_pos_r;
      s1_busy_r   <= sending_nxt;
      s1_done_r   <= done_nxt;
    end
  end

  assign pix_bit  = rd_data_r[s1_bit_r];
  assign high_sel = pix_bit ? high_one_r : high_zero_r;
  assign line_w   = s1_active_r && (s1_phase_r < high_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      line_r <= line_w;
      busy_r <= s1_busy_r;
      done_r <= s1_done_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.data_line  = line_r;
  assign out_ch.busy_res   = busy_r;
  assign out_ch.frame_done = done_r;

endmodule

FILE: src/slpe_checker.sv
// slpe_checker: port-level assertions for serial_led_pulse_encoder.
// Bound to the top level below; no package dependency.

module slpe_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic data_line,
  input logic busy_res,
  input logic frame_done,
  input logic cfg_valid,
  input logic cfg_ready
);

  // a finished frame never reports busy on the same item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> !busy_res)
    else $error("frame_done with busy_res set");

  // input only stalls when a result is waiting and not taken
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_line) && $stable(busy_res)
      && $stable(frame_done))
    else $error("stalled result changed");

  // register writes are never stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

  // a waiting item stays offered until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("item withdrawn before accept");

endmodule

bind serial_led_pulse_encoder slpe_checker u_slpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .data_line  (out_ch.data_line),
  .busy_res   (out_ch.busy_res),
  .frame_done (out_ch.frame_done),
  .cfg_valid  (cfg_ch.valid),
  .cfg_ready  (cfg_ch.ready)
);
